// ===== rtl/vsock_connection_tracker_core_macros.svh =====
// Assertion macros used by the connection tracker checker.
`ifndef VSOCK_CONNECTION_TRACKER_CORE_MACROS_SVH
`define VSOCK_CONNECTION_TRACKER_CORE_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is asserted.
`define VCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define VCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vct_pkg.sv =====
// Types and constants of the vsock connection tracker.
`timescale 1ns / 1ps

package vct_pkg;

    localparam int SLOT_OUT_W = 6;

    localparam logic [15:0] OP_CONN_REQ       = 16'd1;
    localparam logic [15:0] OP_RST            = 16'd3;
    localparam logic [15:0] OP_SHUTDOWN       = 16'd4;
    localparam logic [15:0] OP_RW             = 16'd5;
    localparam logic [15:0] OP_CREDIT_REQUEST = 16'd7;

    localparam logic [2:0] RPL_NONE          = 3'd0;
    localparam logic [2:0] RPL_RESPONSE      = 3'd2;
    localparam logic [2:0] RPL_RST           = 3'd3;
    localparam logic [2:0] RPL_CREDIT_UPDATE = 3'd6;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_OPENED    = 3'd1;
    localparam logic [2:0] EV_REJECTED  = 3'd2;
    localparam logic [2:0] EV_DELIVERED = 3'd3;
    localparam logic [2:0] EV_CLOSED    = 3'd4;
    localparam logic [2:0] EV_REFUSED   = 3'd5;

    localparam logic [63:0] HOST_CID    = 64'd2;
    localparam logic [15:0] TYPE_STREAM = 16'd1;

    typedef struct packed {
        logic [15:0] op;
        logic [63:0] src_cid;
        logic [63:0] dst_cid;
        logic [31:0] sport;
        logic [31:0] dport;
        logic [15:0] pkt_type;
        logic [12:0] payload_len;
        logic        accept_new;
        logic        deliver_ok;
    } req_t;

    typedef struct packed {
        logic                  has_reply;
        logic [2:0]            reply_op;
        logic [63:0]           reply_src_cid;
        logic [63:0]           reply_dst_cid;
        logic [31:0]           reply_sport;
        logic [31:0]           reply_dport;
        logic [15:0]           reply_type;
        logic [31:0]           reply_fwd_cnt;
        logic [2:0]            event_res;
        logic [SLOT_OUT_W-1:0] slot;
    } rsp_t;

    // Connection key and type presented to every cell.
    typedef struct packed {
        logic [63:0] cid;
        logic [31:0] gport;
        logic [31:0] hport;
        logic [15:0] ctype;
    } key_t;

    // Stored contents of one table slot.
    typedef struct packed {
        logic [63:0] cid;
        logic [31:0] gport;
        logic [31:0] hport;
        logic [15:0] ctype;
        logic [31:0] rx;
    } entry_t;

    // Table update command broadcast to the cells.
    typedef struct packed {
        logic        open;       // write key into the lowest free slot
        logic        open_keep;  // leave the opened slot valid
        logic        close_hit;  // free the matching slot
        logic        add_hit;    // add len to the matching slot's count
        logic [12:0] len;
    } upd_t;

endpackage

// ===== rtl/vct_cell.sv =====
// One table slot: stored connection, key compare and priority chain links.
`timescale 1ns / 1ps

module vct_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  vct_pkg::key_t   key,
    input  logic            cmp_en,
    input  vct_pkg::upd_t   cmd,
    input  logic            hit_in,
    input  logic            free_in,
    output logic            hit_out,
    output logic            free_out,
    output logic            sel_hit,
    output logic            sel_free,
    output vct_pkg::entry_t ent
);
    import vct_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    logic   match_reg;
    entry_t ent_reg;
    entry_t ent_next;

    assign hit_out  = hit_in | match_reg;
    assign free_out = free_in | !valid_reg;
    assign sel_hit  = match_reg & !hit_in;
    assign sel_free = !valid_reg & !free_in;
    assign ent      = ent_reg;

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (cmd.open && sel_free)
        begin
            valid_next    = cmd.open_keep;
            ent_next.cid   = key.cid;
            ent_next.gport = key.gport;
            ent_next.hport = key.hport;
            ent_next.ctype = key.ctype;
            ent_next.rx    = '0;
        end
        if (sel_hit && cmd.add_hit)
        begin
            ent_next.rx = ent_reg.rx + {19'd0, cmd.len};
        end
        if (sel_hit && cmd.close_hit)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmp_en)
            begin
                match_reg <= valid_reg && ent_reg.cid == key.cid &&
                             ent_reg.gport == key.gport && ent_reg.hport == key.hport;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== rtl/vsock_connection_tracker_core.sv =====
// Top level of the vsock stream connection tracker.
`timescale 1ns / 1ps
// Usage:
//   Present a guest-sent packet header on req and raise start; the item is
//   taken at a rising edge where start is high and busy is low.
//   Exactly one result per item comes back on rsp, marked by done for a single
//   cycle; the receiver takes it at the edge that ends that cycle and has no
//   way to stall it, so sample rsp whenever done is high.
// Handshake timing:
//   done rises at the end of the update cycle, which follows the compare cycle
//   that the accepting edge starts. busy is high only during the compare cycle,
//   so a new item can be taken in the update cycle, before the last is through.
//   The compare cycle holds the registered key compare in every slot cell, the
//   update cycle the priority chain that picks the matching or lowest free slot.
// Structure:
//   A row of MAX_CONNECTIONS slot cells. Each cell holds one connection and
//   compares it with the broadcast key; hit and free flags ripple from slot 0
//   upward so the lowest slot wins.
// Reset:
//   rst_n clears every slot's valid flag and the handshake state at once;
//   busy is low out of reset, so the block can take items once it is released.
module vsock_connection_tracker_core #(
    parameter int MAX_CONNECTIONS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vct_pkg::req_t req,
    output logic          done,
    output vct_pkg::rsp_t rsp
);
    import vct_pkg::*;

    localparam int SLOT_W = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;

    logic   busy_reg;
    logic   upd_reg;
    logic   done_reg;
    req_t   item_reg;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;
    key_t   key;
    upd_t   cmd;

    logic [MAX_CONNECTIONS:0]   hit_chain;
    logic [MAX_CONNECTIONS:0]   free_chain;
    logic [MAX_CONNECTIONS-1:0] sel_hit;
    logic [MAX_CONNECTIONS-1:0] sel_free;
    entry_t                     ents [MAX_CONNECTIONS];

    entry_t            hit_ent;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic              any_hit;
    logic              any_free;
    logic [31:0]       rx_after;
    logic [15:0]       ent_type;
    logic [15:0]       new_type;
    logic              accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign key.cid   = item_reg.src_cid;
    assign key.gport = item_reg.sport;
    assign key.hport = item_reg.dport;
    assign key.ctype = item_reg.pkt_type;

    assign hit_chain[0]  = 1'b0;
    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_CONNECTIONS; g++)
    begin : g_cell
        vct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key),
            .cmp_en   (busy_reg),
            .cmd      (cmd),
            .hit_in   (hit_chain[g]),
            .free_in  (free_chain[g]),
            .hit_out  (hit_chain[g+1]),
            .free_out (free_chain[g+1]),
            .sel_hit  (sel_hit[g]),
            .sel_free (sel_free[g]),
            .ent      (ents[g])
        );
    end

    assign any_hit  = hit_chain[MAX_CONNECTIONS];
    assign any_free = free_chain[MAX_CONNECTIONS];

    // Read out the selected slot: at most one bit of each select vector is set.
    always_comb
    begin
        hit_ent  = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_CONNECTIONS; i++)
        begin
            if (sel_hit[i])
            begin
                hit_ent = hit_ent | ents[i];
                hit_idx = hit_idx | SLOT_W'(i);
            end
            if (sel_free[i])
            begin
                free_idx = free_idx | SLOT_W'(i);
            end
        end
    end

    assign rx_after = hit_ent.rx + {19'd0, item_reg.payload_len};
    assign ent_type = (hit_ent.ctype != 16'd0) ? hit_ent.ctype : TYPE_STREAM;
    assign new_type = (item_reg.pkt_type != 16'd0) ? item_reg.pkt_type : TYPE_STREAM;

    // Decide the reply, the event and the table update for the held item.
    always_comb
    begin
        rsp_next = '0;
        cmd      = '0;
        cmd.len  = item_reg.payload_len;
        unique case (item_reg.op)
            OP_CONN_REQ:
            begin
                if (any_hit)
                begin
                    // Duplicate request: reset and drop the existing entry.
                    rsp_next.has_reply     = 1'b1;
                    rsp_next.reply_op      = RPL_RST;
                    rsp_next.reply_src_cid = HOST_CID;
                    rsp_next.reply_dst_cid = hit_ent.cid;
                    rsp_next.reply_sport   = hit_ent.hport;
                    rsp_next.reply_dport   = hit_ent.gport;
                    rsp_next.reply_type    = ent_type;
                    rsp_next.reply_fwd_cnt = hit_ent.rx;
                    rsp_next.event_res     = EV_CLOSED;
                    rsp_next.slot          = SLOT_OUT_W'(hit_idx);
                    cmd.close_hit          = upd_reg;
                end
                else if (any_free)
                begin
                    cmd.open               = upd_reg;
                    cmd.open_keep          = item_reg.accept_new;
                    rsp_next.has_reply     = 1'b1;
                    rsp_next.reply_op      = item_reg.accept_new ? RPL_RESPONSE : RPL_RST;
                    rsp_next.reply_src_cid = HOST_CID;
                    rsp_next.reply_dst_cid = item_reg.src_cid;
                    rsp_next.reply_sport   = item_reg.dport;
                    rsp_next.reply_dport   = item_reg.sport;
                    rsp_next.reply_type    = new_type;
                    rsp_next.event_res     = item_reg.accept_new ? EV_OPENED : EV_REJECTED;
                    rsp_next.slot          = SLOT_OUT_W'(free_idx);
                end
                else
                begin
                    // Table full: tableless reset.
                    rsp_next.has_reply     = 1'b1;
                    rsp_next.reply_op      = RPL_RST;
                    rsp_next.reply_src_cid = item_reg.dst_cid;
                    rsp_next.reply_dst_cid = item_reg.src_cid;
                    rsp_next.reply_sport   = item_reg.dport;
                    rsp_next.reply_dport   = item_reg.sport;
                    rsp_next.reply_type    = item_reg.pkt_type;
                end
            end
            OP_RW:
            begin
                if (any_hit)
                begin
                    cmd.add_hit        = upd_reg;
                    rsp_next.slot      = SLOT_OUT_W'(hit_idx);
                    rsp_next.event_res = EV_DELIVERED;
                    if (!item_reg.deliver_ok)
                    begin
                        cmd.close_hit          = upd_reg;
                        rsp_next.has_reply     = 1'b1;
                        rsp_next.reply_op      = RPL_RST;
                        rsp_next.reply_src_cid = HOST_CID;
                        rsp_next.reply_dst_cid = hit_ent.cid;
                        rsp_next.reply_sport   = hit_ent.hport;
                        rsp_next.reply_dport   = hit_ent.gport;
                        rsp_next.reply_type    = ent_type;
                        rsp_next.reply_fwd_cnt = rx_after;
                        rsp_next.event_res     = EV_REFUSED;
                    end
                end
                else
                begin
                    // Data for an unknown connection: tableless reset.
                    rsp_next.has_reply     = 1'b1;
                    rsp_next.reply_op      = RPL_RST;
                    rsp_next.reply_src_cid = item_reg.dst_cid;
                    rsp_next.reply_dst_cid = item_reg.src_cid;
                    rsp_next.reply_sport   = item_reg.dport;
                    rsp_next.reply_dport   = item_reg.sport;
                    rsp_next.reply_type    = item_reg.pkt_type;
                end
            end
            OP_SHUTDOWN:
            begin
                if (any_hit)
                begin
                    rsp_next.has_reply     = 1'b1;
                    rsp_next.reply_op      = RPL_RST;
                    rsp_next.reply_src_cid = HOST_CID;
                    rsp_next.reply_dst_cid = hit_ent.cid;
                    rsp_next.reply_sport   = hit_ent.hport;
                    rsp_next.reply_dport   = hit_ent.gport;
                    rsp_next.reply_type    = ent_type;
                    rsp_next.reply_fwd_cnt = hit_ent.rx;
                    rsp_next.event_res     = EV_CLOSED;
                    rsp_next.slot          = SLOT_OUT_W'(hit_idx);
                    cmd.close_hit          = upd_reg;
                end
            end
            OP_RST:
            begin
                if (any_hit)
                begin
                    rsp_next.event_res = EV_CLOSED;
                    rsp_next.slot      = SLOT_OUT_W'(hit_idx);
                    cmd.close_hit      = upd_reg;
                end
            end
            OP_CREDIT_REQUEST:
            begin
                if (any_hit)
                begin
                    rsp_next.has_reply     = 1'b1;
                    rsp_next.reply_op      = RPL_CREDIT_UPDATE;
                    rsp_next.reply_src_cid = HOST_CID;
                    rsp_next.reply_dst_cid = hit_ent.cid;
                    rsp_next.reply_sport   = hit_ent.hport;
                    rsp_next.reply_dport   = hit_ent.gport;
                    rsp_next.reply_type    = ent_type;
                    rsp_next.reply_fwd_cnt = hit_ent.rx;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Handshake: compare cycle (busy), then update cycle, then result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            upd_reg  <= busy_reg;
            done_reg <= upd_reg;
        end
    end

    // Hold the item and the result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (upd_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== rtl/vct_checker.sv =====
// Port-level checker for the connection tracker, bound to the top level.
`timescale 1ns / 1ps
`include "vsock_connection_tracker_core_macros.svh"

module vct_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input vct_pkg::rsp_t rsp
);
    import vct_pkg::*;

    `VCT_ASSERT(a_busy_one_cycle, busy |=> !busy, "busy held longer than one cycle")
    `VCT_ASSERT(a_done_follows, (start && !busy) |-> ##3 done, "result missing after item")
    `VCT_ASSERT(a_done_has_item, done |-> $past(busy, 2), "result without an item")
    `VCT_ASSERT(a_no_reply_clean,
                (done && !rsp.has_reply) |-> (rsp.reply_op == RPL_NONE && rsp.reply_fwd_cnt == 32'd0),
                "reply fields set without a reply")
    `VCT_ASSERT(a_no_event_slot, (done && rsp.event_res == EV_NONE) |-> rsp.slot == '0,
                "slot set without an event")

endmodule

bind vsock_connection_tracker_core vct_checker u_vct_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the vsock stream connection tracker.
`timescale 1ns / 1ps

module tb_top;

    import vct_pkg::*;

    localparam int TRACK_SLOTS   = 8;
    localparam int POOL_SIZE     = 12;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CALM_ITEMS    = 100;

    // Packet op codes that the package does not name; the block ignores them.
    localparam logic [15:0] PKT_OP_RESPONSE      = 16'd2;
    localparam logic [15:0] PKT_OP_CREDIT_UPDATE = 16'd6;
    localparam logic [15:0] PKT_OP_UNKNOWN_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [63:0] cid;
        logic [31:0] gport;
        logic [31:0] hport;
    } conn_key_t;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    req_t  req   = '0;
    logic  busy;
    logic  done;
    rsp_t  rsp;

    // Predicted copy of the connection table.
    logic        conn_valid [TRACK_SLOTS];
    logic [63:0] conn_cid   [TRACK_SLOTS];
    logic [31:0] conn_gport [TRACK_SLOTS];
    logic [31:0] conn_hport [TRACK_SLOTS];
    logic [15:0] conn_kind  [TRACK_SLOTS];
    logic [31:0] conn_rx    [TRACK_SLOTS];

    rsp_t      expected_replies [$];
    rsp_t      oldest_reply;
    conn_key_t key_pool [POOL_SIZE];
    int        mismatches = 0;

    vsock_connection_tracker_core #(
        .MAX_CONNECTIONS(TRACK_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic int lookup_conn(input req_t p);
        for (int i = 0; i < TRACK_SLOTS; i++)
        begin
            if (conn_valid[i] && conn_cid[i] == p.src_cid &&
                conn_gport[i] == p.sport && conn_hport[i] == p.dport)
                return i;
        end
        return -1;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < TRACK_SLOTS; i++)
        begin
            if (!conn_valid[i])
                return i;
        end
        return -1;
    endfunction

    function automatic rsp_t entry_reply(input int s, input logic [2:0] rop);
        rsp_t r;
        r = '0;
        r.has_reply     = 1'b1;
        r.reply_op      = rop;
        r.reply_src_cid = HOST_CID;
        r.reply_dst_cid = conn_cid[s];
        r.reply_sport   = conn_hport[s];
        r.reply_dport   = conn_gport[s];
        r.reply_type    = (conn_kind[s] != 16'd0) ? conn_kind[s] : TYPE_STREAM;
        r.reply_fwd_cnt = conn_rx[s];
        return r;
    endfunction

    // Reset answer built from the header alone: addresses swapped.
    function automatic rsp_t tableless_rst(input req_t p);
        rsp_t r;
        r = '0;
        r.has_reply     = 1'b1;
        r.reply_op      = RPL_RST;
        r.reply_src_cid = p.dst_cid;
        r.reply_dst_cid = p.src_cid;
        r.reply_sport   = p.dport;
        r.reply_dport   = p.sport;
        r.reply_type    = p.pkt_type;
        return r;
    endfunction

    function automatic rsp_t predict_reply(input req_t p);
        rsp_t r;
        int   s;
        r = '0;
        s = lookup_conn(p);
        case (p.op)
            OP_CONN_REQ:
            begin
                if (s >= 0)
                begin
                    // duplicate request tears the connection down
                    r = entry_reply(s, RPL_RST);
                    r.event_res = EV_CLOSED;
                    r.slot = s[SLOT_OUT_W-1:0];
                    conn_valid[s] = 1'b0;
                end
                else
                begin
                    s = lowest_free();
                    if (s < 0)
                        r = tableless_rst(p);
                    else
                    begin
                        conn_valid[s] = 1'b1;
                        conn_cid[s]   = p.src_cid;
                        conn_gport[s] = p.sport;
                        conn_hport[s] = p.dport;
                        conn_kind[s]  = p.pkt_type;
                        conn_rx[s]    = 32'd0;
                        if (p.accept_new)
                        begin
                            r = entry_reply(s, RPL_RESPONSE);
                            r.event_res = EV_OPENED;
                        end
                        else
                        begin
                            r = entry_reply(s, RPL_RST);
                            r.event_res = EV_REJECTED;
                            conn_valid[s] = 1'b0;
                        end
                        r.slot = s[SLOT_OUT_W-1:0];
                    end
                end
            end
            OP_RW:
            begin
                if (s < 0)
                    r = tableless_rst(p);
                else
                begin
                    conn_rx[s] = conn_rx[s] + {19'd0, p.payload_len};
                    if (p.deliver_ok)
                        r.event_res = EV_DELIVERED;
                    else
                    begin
                        r = entry_reply(s, RPL_RST);
                        r.event_res = EV_REFUSED;
                        conn_valid[s] = 1'b0;
                    end
                    r.slot = s[SLOT_OUT_W-1:0];
                end
            end
            OP_SHUTDOWN:
            begin
                if (s >= 0)
                begin
                    r = entry_reply(s, RPL_RST);
                    r.event_res = EV_CLOSED;
                    r.slot = s[SLOT_OUT_W-1:0];
                    conn_valid[s] = 1'b0;
                end
            end
            OP_RST:
            begin
                if (s >= 0)
                begin
                    r.event_res = EV_CLOSED;
                    r.slot = s[SLOT_OUT_W-1:0];
                    conn_valid[s] = 1'b0;
                end
            end
            OP_CREDIT_REQUEST:
            begin
                if (s >= 0)
                    r = entry_reply(s, RPL_CREDIT_UPDATE);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Header builders
    // ------------------------------------------------------------------
    function automatic req_t make_header(input logic [15:0] op, input conn_key_t k,
                                         input logic [15:0] ptype, input logic [12:0] plen,
                                         input logic acc, input logic dlv);
        req_t h;
        h.op          = op;
        h.src_cid     = k.cid;
        h.dst_cid     = HOST_CID;
        h.sport       = k.gport;
        h.dport       = k.hport;
        h.pkt_type    = ptype;
        h.payload_len = plen;
        h.accept_new  = acc;
        h.deliver_ok  = dlv;
        return h;
    endfunction

    function automatic conn_key_t fresh_key();
        conn_key_t k;
        k.cid   = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(3, 40))
                                               : {$urandom(), $urandom()};
        k.gport = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1024, 1040)) : $urandom();
        k.hport = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 8)) : $urandom();
        return k;
    endfunction

    function automatic req_t random_header();
        req_t h;
        h.op          = 16'($urandom());
        h.src_cid     = {$urandom(), $urandom()};
        h.dst_cid     = {$urandom(), $urandom()};
        h.sport       = $urandom();
        h.dport       = $urandom();
        h.pkt_type    = 16'($urandom());
        h.payload_len = 13'($urandom());
        h.accept_new  = 1'($urandom());
        h.deliver_ok  = 1'($urandom());
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Present one header and hold it until the block takes it; start stays
    // high so a following item goes back to back.
    task automatic send_header(input req_t p);
        @(negedge clk);
        start <= 1'b1;
        req   <= p;
        do
            @(posedge clk);
        while (busy);
        expected_replies.push_back(predict_reply(p));
    endtask

    // Drop start and put junk on the header lines for a hold-off of length n.
    task automatic hold_off(input int n);
        @(negedge clk);
        start <= 1'b0;
        req   <= random_header();
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic wait_all_replies();
        @(negedge clk);
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t ns: result with no item outstanding, actual %h", $time, rsp);
                mismatches++;
            end
            else
            begin
                oldest_reply = expected_replies.pop_front();
                report_field("has_reply", 64'(oldest_reply.has_reply), 64'(rsp.has_reply));
                report_field("reply_op", 64'(oldest_reply.reply_op), 64'(rsp.reply_op));
                report_field("reply_src_cid", oldest_reply.reply_src_cid, rsp.reply_src_cid);
                report_field("reply_dst_cid", oldest_reply.reply_dst_cid, rsp.reply_dst_cid);
                report_field("reply_sport", 64'(oldest_reply.reply_sport),
                             64'(rsp.reply_sport));
                report_field("reply_dport", 64'(oldest_reply.reply_dport),
                             64'(rsp.reply_dport));
                report_field("reply_type", 64'(oldest_reply.reply_type), 64'(rsp.reply_type));
                report_field("reply_fwd_cnt", 64'(oldest_reply.reply_fwd_cnt),
                             64'(rsp.reply_fwd_cnt));
                report_field("event_res", 64'(oldest_reply.event_res), 64'(rsp.event_res));
                report_field("slot", 64'(oldest_reply.slot), 64'(rsp.slot));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Open, move data past the nominal payload limit, query credit, close.
    task automatic test_connection_lifecycle();
        conn_key_t k;
        k = {64'd3, 32'd1024, 32'hFFFF_FFFF};
        send_header(make_header(OP_CONN_REQ, k, 16'd0, 13'd0, 1'b1, 1'b1));
        send_header(make_header(OP_RW, k, TYPE_STREAM, 13'd4096, 1'b0, 1'b1));
        hold_off(3);
        send_header(make_header(OP_RW, k, TYPE_STREAM, 13'h1FFF, 1'b1, 1'b1));
        send_header(make_header(OP_CREDIT_REQUEST, k, TYPE_STREAM, 13'd0, 1'b0, 1'b0));
        send_header(make_header(OP_SHUTDOWN, k, TYPE_STREAM, 13'd0, 1'b0, 1'b0));
        // connection is gone now, so this one is ignored
        send_header(make_header(OP_SHUTDOWN, k, TYPE_STREAM, 13'd0, 1'b1, 1'b1));
    endtask

    task automatic test_reject_and_duplicate();
        conn_key_t k;
        k = {64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0};
        send_header(make_header(OP_CONN_REQ, k, TYPE_STREAM, 13'd0, 1'b0, 1'b1));
        send_header(make_header(OP_CONN_REQ, k, 16'hFFFF, 13'd0, 1'b1, 1'b0));
        send_header(make_header(OP_CONN_REQ, k, TYPE_STREAM, 13'd0, 1'b1, 1'b1));
        hold_off(1);
        send_header(make_header(OP_RST, k, TYPE_STREAM, 13'd0, 1'b1, 1'b1));
    endtask

    // Fill every slot, most with edge-valued keys, overflow, then free and reuse.
    task automatic test_table_capacity();
        conn_key_t spare;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i].cid   = (i == 0) ? '1 : (i == 1) ? '0 : {$urandom(), $urandom()};
            key_pool[i].gport = (i == 2) ? '1 : (i == 3) ? '0 : $urandom();
            key_pool[i].hport = (i == 4) ? '1 : (i == 5) ? '0 : $urandom();
        end
        // near miss of the first key: same guest, neighboring host port
        key_pool[TRACK_SLOTS] = key_pool[0];
        key_pool[TRACK_SLOTS].hport[0] = ~key_pool[0].hport[0];
        spare = key_pool[TRACK_SLOTS];
        for (int i = 0; i < TRACK_SLOTS; i++)
            send_header(make_header(OP_CONN_REQ, key_pool[i],
                                    (i == 7) ? 16'hFFFF : (i[0] ? 16'd0 : TYPE_STREAM),
                                    13'd0, 1'b1, 1'b0));
        send_header(make_header(OP_CONN_REQ, spare, 16'h5A5A, 13'd0, 1'b1, 1'b1));
        send_header(make_header(OP_RW, spare, TYPE_STREAM, 13'd100, 1'b1, 1'b1));
        send_header(make_header(OP_RST, key_pool[3], TYPE_STREAM, 13'd0, 1'b0, 1'b0));
        send_header(make_header(OP_RW, key_pool[5], TYPE_STREAM, 13'd0, 1'b1, 1'b0));
        send_header(make_header(OP_CONN_REQ, spare, TYPE_STREAM, 13'd0, 1'b1, 1'b1));
        send_header(make_header(PKT_OP_RESPONSE, key_pool[0], TYPE_STREAM, 13'd0,
                                1'b1, 1'b1));
        send_header(make_header(PKT_OP_CREDIT_UPDATE, key_pool[0], TYPE_STREAM, 13'd0,
                                1'b1, 1'b1));
        send_header(make_header(PKT_OP_UNKNOWN_MAX, key_pool[0], TYPE_STREAM, 13'd0,
                                1'b1, 1'b1));
    endtask

    // Mostly well-formed traffic on a small key pool so connections open,
    // carry data and close; some strangers, near misses and junk op codes.
    task automatic test_random_traffic();
        conn_key_t k;
        req_t      h;
        int        idx;
        int        pick;
        int        flip;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 99) < 6)
                key_pool[idx] = fresh_key();
            k = key_pool[idx];
            pick = $urandom_range(0, 99);
            if (pick < 5)
                k = fresh_key();
            else if (pick < 10)
            begin
                flip = $urandom_range(0, 127);
                k = conn_key_t'(k ^ (128'd1 << flip));
            end
            h = make_header(OP_CONN_REQ, k, TYPE_STREAM, 13'd0,
                            $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 88);
            pick = $urandom_range(0, 99);
            if (pick < 28)
                h.op = OP_CONN_REQ;
            else if (pick < 58)
                h.op = OP_RW;
            else if (pick < 66)
                h.op = OP_SHUTDOWN;
            else if (pick < 73)
                h.op = OP_RST;
            else if (pick < 83)
                h.op = OP_CREDIT_REQUEST;
            else if (pick < 87)
                h.op = PKT_OP_RESPONSE;
            else if (pick < 91)
                h.op = PKT_OP_CREDIT_UPDATE;
            else
                h.op = 16'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 15)
                h.pkt_type = 16'd0;
            else if (pick < 30)
                h.pkt_type = 16'($urandom());
            h.payload_len = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                                         : 13'($urandom_range(0, 4096));
            if ($urandom_range(0, 3) == 0)
                h.dst_cid = {$urandom(), $urandom()};
            // hold the sender once until the table has answered everything
            if (n == RANDOM_ITEMS / 2)
                wait_all_replies();
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < 25)
                hold_off($urandom_range(1, 17));
            send_header(h);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < TRACK_SLOTS; i++)
            conn_valid[i] = 1'b0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        test_connection_lifecycle();
        test_reject_and_duplicate();
        test_table_capacity();
        test_random_traffic();

        wait_all_replies();
        repeat (4)
            @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
